// ===== rtl/cumulative_frequency_table_core_macros.svh =====
// Assertion macros for the cumulative frequency table core.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef CUMULATIVE_FREQUENCY_TABLE_CORE_MACROS_SVH
`define CUMULATIVE_FREQUENCY_TABLE_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, sampled on clk, off while in reset
`define CFT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define CFT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CFT_ASSERT_IMPL(lbl, ante, cons, msg)
`define CFT_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/cft_pkg.sv =====
// Shared constants, codes and helpers for the cumulative frequency table core.
// No dependencies.
`timescale 1ns / 1ps

package cft_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int COUNT_BITS  = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int POS_W       = ADDR_W + 1;
    localparam int SYM_W       = 9;
    localparam int AMT_W       = 16;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;

    // tree positions with a fixed role
    localparam int ESC_NODE   = 1;
    localparam int SENT_NODE  = 2;
    localparam int FIRST_NODE = 3;

    localparam logic [MODE_W-1:0] MODE_INC    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECODE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF   = 2'd2;

    // lowest set bit of a tree position
    function automatic logic [POS_W-1:0] lowbit(input logic [POS_W-1:0] x);
        return x & (~x + POS_W'(1));
    endfunction

endpackage

// ===== rtl/cumulative_frequency_table_core.sv =====
// Cumulative frequency table core: adaptive tree of partial counts for an arithmetic coder.
// Depends on cft_pkg and cumulative_frequency_table_core_macros.svh.
// Each tree node visited goes through the single registered read port and the one
// shared 33-bit adder.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: asynchronous; afterwards a clearing pass writes every table entry with busy high.
// The result is on the outputs for one cycle with done; the receiver cannot stall.
`timescale 1ns / 1ps
`include "cumulative_frequency_table_core_macros.svh"

module cumulative_frequency_table_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    output logic                              done,
    input  logic [cft_pkg::MODE_W-1:0]        mode,
    input  logic [cft_pkg::SYM_W-1:0]         symbol_in,
    input  logic                              sentinel_in,
    input  logic [cft_pkg::AMT_W-1:0]         amount,
    input  logic [cft_pkg::COUNT_BITS-1:0]    target,
    output logic [cft_pkg::SYM_W-1:0]         symbol_out,
    output logic                              sentinel_out,
    output logic                              escape_out,
    output logic [cft_pkg::COUNT_BITS-1:0]    lower_bound,
    output logic [cft_pkg::COUNT_BITS-1:0]    sym_count,
    output logic [cft_pkg::COUNT_BITS-1:0]    total_out,
    output logic [cft_pkg::STATUS_W-1:0]      status
);

    localparam int CW = cft_pkg::COUNT_BITS;
    localparam int AW = cft_pkg::ADDR_W;
    localparam int PW = cft_pkg::POS_W;
    localparam int SW = cft_pkg::SYM_W;

    localparam logic [4:0] S_CLR       = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_NC_INIT   = 5'd2;
    localparam logic [4:0] S_NC_CHK    = 5'd3;
    localparam logic [4:0] S_NC_OP     = 5'd4;
    localparam logic [4:0] S_INC_START = 5'd5;
    localparam logic [4:0] S_INC_T1    = 5'd6;
    localparam logic [4:0] S_INC_T2    = 5'd7;
    localparam logic [4:0] S_INC_E     = 5'd8;
    localparam logic [4:0] S_CH_RD     = 5'd9;
    localparam logic [4:0] S_CH_WR     = 5'd10;
    localparam logic [4:0] S_INC_C     = 5'd11;
    localparam logic [4:0] S_LK        = 5'd12;
    localparam logic [4:0] S_PB_UP_CHK = 5'd13;
    localparam logic [4:0] S_PB_UP_OP  = 5'd14;
    localparam logic [4:0] S_PB_DN_CHK = 5'd15;
    localparam logic [4:0] S_PB_DN_OP  = 5'd16;
    localparam logic [4:0] S_DC_CHK    = 5'd17;
    localparam logic [4:0] S_DC_P_RD   = 5'd18;
    localparam logic [4:0] S_DC_P_OP   = 5'd19;
    localparam logic [4:0] S_DC_M_CHK  = 5'd20;
    localparam logic [4:0] S_DC_M_ACC  = 5'd21;
    localparam logic [4:0] S_DC_M_PART = 5'd22;
    localparam logic [4:0] S_DC_M_CMP  = 5'd23;
    localparam logic [4:0] S_DC_LB     = 5'd24;
    localparam logic [4:0] S_FIN       = 5'd25;

    // kind of result built in the finishing state
    localparam logic [1:0] K_ZERO = 2'd0;
    localparam logic [1:0] K_ESC  = 2'd1;
    localparam logic [1:0] K_SYM  = 2'd2;

    // control state
    logic [4:0]                       state_reg, state_next;
    logic [PW-1:0]                    q_reg, q_next;
    logic [AW-1:0]                    top_reg, top_next;
    logic [CW-1:0]                    total_reg, total_next;
    logic [CW-1:0]                    esc_reg, esc_next;
    logic                             done_reg, done_next;

    // working registers
    logic [cft_pkg::MODE_W-1:0]       mode_reg, mode_next;
    logic [PW-1:0]                    s_reg, s_next;
    logic [PW-1:0]                    p_reg, p_next;
    logic [PW-1:0]                    z_reg, z_next;
    logic [PW-1:0]                    m_reg, m_next;
    logic                             first_reg, first_next;
    logic                             dinc_reg, dinc_next;
    logic                             ddec_reg, ddec_next;
    logic [cft_pkg::AMT_W-1:0]        amt_reg, amt_next;
    logic [CW-1:0]                    tgt0_reg, tgt0_next;
    logic [CW-1:0]                    tgt_reg, tgt_next;
    logic [CW-1:0]                    lb_reg, lb_next;
    logic [CW-1:0]                    cnt_reg, cnt_next;
    logic [CW-1:0]                    acc_reg, acc_next;
    logic [CW-1:0]                    e_reg, e_next;
    logic [CW-1:0]                    ts_reg, ts_next;
    logic [CW-1:0]                    dv_reg, dv_next;
    logic [CW-1:0]                    part_reg, part_next;
    logic [CW:0]                      tmp_reg, tmp_next;
    logic [cft_pkg::STATUS_W-1:0]     status_reg, status_next;
    logic [1:0]                       kind_reg, kind_next;

    // result registers
    logic [SW-1:0]                    symbol_out_reg, symbol_out_next;
    logic                             sentinel_out_reg, sentinel_out_next;
    logic                             escape_out_reg, escape_out_next;
    logic [CW-1:0]                    lower_bound_reg, lower_bound_next;
    logic [CW-1:0]                    sym_count_reg, sym_count_next;
    logic [CW-1:0]                    total_out_reg, total_out_next;
    logic [cft_pkg::STATUS_W-1:0]     status_out_reg, status_out_next;

    // tree store, one write and one registered read per cycle
    logic [CW-1:0]                    mem [cft_pkg::TABLE_DEPTH];
    logic [CW-1:0]                    mem_q;
    logic                             rd_esc_reg;
    logic [AW-1:0]                    rd_addr;
    logic                             mem_we;
    logic [AW-1:0]                    mem_wa;
    logic [CW-1:0]                    mem_wd;
    logic [CW-1:0]                    rd_val;

    // shared adder/subtractor
    logic [CW:0]                      alu_a, alu_b, alu_res;
    logic                             alu_sub;

    logic [SW:0]                      pos_wide;
    logic                             pos_ok;
    logic [PW-1:0]                    nc_sum, nc_lim, nc_z;
    logic [PW-1:0]                    sm;
    logic [PW-1:0]                    p_clr;

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign symbol_out   = symbol_out_reg;
    assign sentinel_out = sentinel_out_reg;
    assign escape_out   = escape_out_reg;
    assign lower_bound  = lower_bound_reg;
    assign sym_count    = sym_count_reg;
    assign total_out    = total_out_reg;
    assign status       = status_out_reg;

    // node 1 lives in esc_reg; the memory copy is never read
    assign rd_val = rd_esc_reg ? esc_reg : mem_q;

    assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + {{CW{1'b0}}, alu_sub};

    assign pos_wide = sentinel_in ? (SW+1)'(cft_pkg::SENT_NODE)
                                  : {1'b0, symbol_in} + (SW+1)'(cft_pkg::FIRST_NODE);
    assign pos_ok   = 32'(pos_wide) < 32'(cft_pkg::TABLE_DEPTH);

    // end of the child walk inside a node count, clipped at one past the top position
    assign nc_sum = s_reg + cft_pkg::lowbit(s_reg);
    assign nc_lim = PW'(top_reg) + PW'(1);
    assign nc_z   = (nc_sum > nc_lim) ? nc_lim : nc_sum;

    assign sm    = s_reg + m_reg;
    assign p_clr = p_reg & (p_reg - PW'(1));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        mem_q      <= mem[rd_addr];
        rd_esc_reg <= (rd_addr == AW'(cft_pkg::ESC_NODE));
    end

    always_comb
    begin
        state_next        = state_reg;
        q_next            = q_reg;
        top_next          = top_reg;
        total_next        = total_reg;
        esc_next          = esc_reg;
        done_next         = 1'b0;
        mode_next         = mode_reg;
        s_next            = s_reg;
        p_next            = p_reg;
        z_next            = z_reg;
        m_next            = m_reg;
        first_next        = first_reg;
        dinc_next         = dinc_reg;
        ddec_next         = ddec_reg;
        amt_next          = amt_reg;
        tgt0_next         = tgt0_reg;
        tgt_next          = tgt_reg;
        lb_next           = lb_reg;
        cnt_next          = cnt_reg;
        acc_next          = acc_reg;
        e_next            = e_reg;
        ts_next           = ts_reg;
        dv_next           = dv_reg;
        part_next         = part_reg;
        tmp_next          = tmp_reg;
        status_next       = status_reg;
        kind_next         = kind_reg;
        symbol_out_next   = symbol_out_reg;
        sentinel_out_next = sentinel_out_reg;
        escape_out_next   = escape_out_reg;
        lower_bound_next  = lower_bound_reg;
        sym_count_next    = sym_count_reg;
        total_out_next    = total_out_reg;
        status_out_next   = status_out_reg;
        alu_a             = '0;
        alu_b             = '0;
        alu_sub           = 1'b0;
        rd_addr           = '0;
        mem_we            = 1'b0;
        mem_wa            = '0;
        mem_wd            = '0;

        case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1;
                mem_wa = q_reg[AW-1:0];
                mem_wd = (q_reg == PW'(cft_pkg::SENT_NODE)) ? CW'(1) : '0;
                q_next = q_reg + PW'(1);
                if (q_reg[AW-1:0] == AW'(cft_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (start)
                begin
                    mode_next   = mode;
                    amt_next    = amount;
                    tgt0_next   = target;
                    tgt_next    = target;
                    lb_next     = '0;
                    acc_next    = '0;
                    status_next = cft_pkg::ST_OK;
                    s_next      = PW'(pos_wide);
                    if (mode inside {cft_pkg::MODE_INC, cft_pkg::MODE_LOOKUP})
                    begin
                        if (!pos_ok)
                        begin
                            status_next = cft_pkg::ST_RANGE;
                            kind_next   = K_ESC;
                            state_next  = S_FIN;
                        end
                        else if (PW'(pos_wide) <= PW'(top_reg))
                        begin
                            state_next = S_NC_INIT;
                        end
                        else
                        begin
                            cnt_next   = '0;
                            state_next = (mode == cft_pkg::MODE_INC) ? S_INC_START : S_LK;
                        end
                    end
                    else if (mode == cft_pkg::MODE_DECODE)
                    begin
                        state_next = S_DC_CHK;
                    end
                    else
                    begin
                        kind_next  = K_ZERO;
                        state_next = S_FIN;
                    end
                end
            end

            S_NC_INIT:
            begin
                q_next     = s_reg;
                z_next     = nc_z;
                first_next = 1'b1;
                state_next = S_NC_CHK;
            end

            S_NC_CHK:
            begin
                if (first_reg || (q_reg < z_reg))
                begin
                    rd_addr    = q_reg[AW-1:0];
                    state_next = S_NC_OP;
                end
                else
                begin
                    cnt_next = acc_reg;
                    case (mode_reg)
                        cft_pkg::MODE_INC:    state_next = S_INC_START;
                        cft_pkg::MODE_LOOKUP: state_next = S_LK;
                        default:
                        begin
                            kind_next  = K_SYM;
                            state_next = S_FIN;
                        end
                    endcase
                end
            end

            S_NC_OP:
            begin
                alu_a   = {1'b0, acc_reg};
                alu_b   = {1'b0, rd_val};
                alu_sub = 1'b1;
                if (first_reg)
                begin
                    acc_next = rd_val;
                    q_next   = q_reg + PW'(1);
                end
                else
                begin
                    acc_next = alu_res[CW-1:0];
                    q_next   = q_reg + cft_pkg::lowbit(q_reg);
                end
                first_next = 1'b0;
                state_next = S_NC_CHK;
            end

            S_INC_START:
            begin
                dinc_next = 1'b0;
                ddec_next = 1'b0;
                if (amt_reg == '0)
                begin
                    state_next = S_LK;
                end
                else
                begin
                    // singleton bookkeeping, skipped for the sentinel
                    if (s_reg != PW'(cft_pkg::SENT_NODE))
                    begin
                        if (cnt_reg == '0)
                        begin
                            dinc_next = (amt_reg == cft_pkg::AMT_W'(1));
                        end
                        else if (cnt_reg == CW'(1))
                        begin
                            ddec_next = 1'b1;
                        end
                    end
                    state_next = S_INC_T1;
                end
            end

            S_INC_T1:
            begin
                alu_a      = {1'b0, total_reg};
                alu_b      = (CW+1)'(amt_reg);
                tmp_next   = alu_res;
                state_next = S_INC_T2;
            end

            S_INC_T2:
            begin
                alu_a   = tmp_reg;
                alu_b   = (CW+1)'(dinc_reg | ddec_reg);
                alu_sub = ddec_reg;
                if (alu_res[CW])
                begin
                    status_next = cft_pkg::ST_OVF;
                    state_next  = S_LK;
                end
                else
                begin
                    total_next = alu_res[CW-1:0];
                    state_next = S_INC_E;
                end
            end

            S_INC_E:
            begin
                alu_a      = {1'b0, esc_reg};
                alu_b      = (CW+1)'(dinc_reg | ddec_reg);
                alu_sub    = ddec_reg;
                esc_next   = alu_res[CW-1:0];
                p_next     = s_reg;
                state_next = S_CH_RD;
            end

            S_CH_RD:
            begin
                rd_addr    = p_reg[AW-1:0];
                state_next = S_CH_WR;
            end

            S_CH_WR:
            begin
                alu_a  = {1'b0, rd_val};
                alu_b  = (CW+1)'(amt_reg);
                mem_we = 1'b1;
                mem_wa = p_reg[AW-1:0];
                mem_wd = alu_res[CW-1:0];
                // drop the lowest set bit to reach the next covering node
                p_next = p_clr;
                state_next = (p_clr == '0) ? S_INC_C : S_CH_RD;
            end

            S_INC_C:
            begin
                alu_a    = {1'b0, cnt_reg};
                alu_b    = (CW+1)'(amt_reg);
                cnt_next = alu_res[CW-1:0];
                if (s_reg > PW'(top_reg))
                begin
                    top_next = s_reg[AW-1:0];
                end
                state_next = S_LK;
            end

            S_LK:
            begin
                if (cnt_reg == '0)
                begin
                    kind_next  = K_ESC;
                    state_next = S_FIN;
                end
                else
                begin
                    p_next     = PW'(1);
                    acc_next   = '0;
                    state_next = S_PB_UP_CHK;
                end
            end

            S_PB_UP_CHK:
            begin
                if (p_reg < s_reg)
                begin
                    rd_addr    = p_reg[AW-1:0];
                    state_next = S_PB_UP_OP;
                end
                else
                begin
                    q_next     = s_reg;
                    state_next = S_PB_DN_CHK;
                end
            end

            S_PB_UP_OP:
            begin
                alu_a      = {1'b0, acc_reg};
                alu_b      = {1'b0, rd_val};
                acc_next   = alu_res[CW-1:0];
                p_next     = {p_reg[PW-2:0], 1'b0};
                state_next = S_PB_UP_CHK;
            end

            S_PB_DN_CHK:
            begin
                if ((q_reg != p_reg) && (q_reg <= PW'(top_reg)))
                begin
                    rd_addr    = q_reg[AW-1:0];
                    state_next = S_PB_DN_OP;
                end
                else
                begin
                    lb_next    = acc_reg;
                    kind_next  = K_SYM;
                    state_next = S_FIN;
                end
            end

            S_PB_DN_OP:
            begin
                alu_a      = {1'b0, acc_reg};
                alu_b      = {1'b0, rd_val};
                alu_sub    = 1'b1;
                acc_next   = alu_res[CW-1:0];
                q_next     = q_reg + cft_pkg::lowbit(q_reg);
                state_next = S_PB_DN_CHK;
            end

            S_DC_CHK:
            begin
                alu_a   = {1'b0, tgt_reg};
                alu_b   = {1'b0, total_reg};
                alu_sub = 1'b1;
                if (!alu_res[CW])
                begin
                    status_next = cft_pkg::ST_RANGE;
                    kind_next   = K_ZERO;
                    state_next  = S_FIN;
                end
                else
                begin
                    p_next     = PW'(1);
                    state_next = S_DC_P_RD;
                end
            end

            S_DC_P_RD:
            begin
                rd_addr    = p_reg[AW-1:0];
                state_next = S_DC_P_OP;
            end

            S_DC_P_OP:
            begin
                alu_a   = {1'b0, tgt_reg};
                alu_b   = {1'b0, rd_val};
                alu_sub = 1'b1;
                if (({p_reg[PW-2:0], 1'b0} <= PW'(top_reg)) && !alu_res[CW])
                begin
                    tgt_next   = alu_res[CW-1:0];
                    p_next     = {p_reg[PW-2:0], 1'b0};
                    state_next = S_DC_P_RD;
                end
                else
                begin
                    ts_next    = rd_val;
                    s_next     = p_reg;
                    m_next     = {1'b0, p_reg[PW-1:1]};
                    e_next     = '0;
                    state_next = S_DC_M_CHK;
                end
            end

            S_DC_M_CHK:
            begin
                if (m_reg == '0)
                begin
                    state_next = S_DC_LB;
                end
                else if (sm <= PW'(top_reg))
                begin
                    rd_addr    = sm[AW-1:0];
                    state_next = S_DC_M_ACC;
                end
                else
                begin
                    m_next = {1'b0, m_reg[PW-1:1]};
                end
            end

            S_DC_M_ACC:
            begin
                alu_a      = {1'b0, e_reg};
                alu_b      = {1'b0, rd_val};
                e_next     = alu_res[CW-1:0];
                dv_next    = rd_val;
                state_next = S_DC_M_PART;
            end

            S_DC_M_PART:
            begin
                alu_a      = {1'b0, ts_reg};
                alu_b      = {1'b0, e_reg};
                alu_sub    = 1'b1;
                part_next  = alu_res[CW-1:0];
                state_next = S_DC_M_CMP;
            end

            S_DC_M_CMP:
            begin
                alu_a   = {1'b0, tgt_reg};
                alu_b   = {1'b0, part_reg};
                alu_sub = 1'b1;
                if (!alu_res[CW])
                begin
                    // advance into the right subtree
                    tgt_next = alu_res[CW-1:0];
                    s_next   = sm;
                    e_next   = '0;
                    ts_next  = dv_reg;
                end
                m_next     = {1'b0, m_reg[PW-1:1]};
                state_next = S_DC_M_CHK;
            end

            S_DC_LB:
            begin
                // everything taken off the target lies below the symbol
                alu_a   = {1'b0, tgt0_reg};
                alu_b   = {1'b0, tgt_reg};
                alu_sub = 1'b1;
                lb_next = alu_res[CW-1:0];
                if (s_reg == PW'(cft_pkg::ESC_NODE))
                begin
                    kind_next  = K_ESC;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_NC_INIT;
                end
            end

            S_FIN:
            begin
                done_next       = 1'b1;
                total_out_next  = total_reg;
                status_out_next = status_reg;
                case (kind_reg)
                    K_ESC:
                    begin
                        symbol_out_next   = SW'(top_reg - AW'(cft_pkg::SENT_NODE));
                        sentinel_out_next = 1'b0;
                        escape_out_next   = 1'b1;
                        lower_bound_next  = lb_reg;
                        sym_count_next    = esc_reg;
                    end
                    K_SYM:
                    begin
                        if (s_reg == PW'(cft_pkg::SENT_NODE))
                        begin
                            symbol_out_next   = '0;
                            sentinel_out_next = 1'b1;
                        end
                        else
                        begin
                            symbol_out_next   = SW'(s_reg - PW'(cft_pkg::FIRST_NODE));
                            sentinel_out_next = 1'b0;
                        end
                        escape_out_next  = 1'b0;
                        lower_bound_next = lb_reg;
                        sym_count_next   = cnt_reg;
                    end
                    default:
                    begin
                        symbol_out_next   = '0;
                        sentinel_out_next = 1'b0;
                        escape_out_next   = 1'b0;
                        lower_bound_next  = '0;
                        sym_count_next    = '0;
                    end
                endcase
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            q_reg     <= '0;
            top_reg   <= AW'(cft_pkg::SENT_NODE);
            total_reg <= CW'(2);
            esc_reg   <= CW'(1);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            q_reg     <= q_next;
            top_reg   <= top_next;
            total_reg <= total_next;
            esc_reg   <= esc_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg         <= mode_next;
        s_reg            <= s_next;
        p_reg            <= p_next;
        z_reg            <= z_next;
        m_reg            <= m_next;
        first_reg        <= first_next;
        dinc_reg         <= dinc_next;
        ddec_reg         <= ddec_next;
        amt_reg          <= amt_next;
        tgt0_reg         <= tgt0_next;
        tgt_reg          <= tgt_next;
        lb_reg           <= lb_next;
        cnt_reg          <= cnt_next;
        acc_reg          <= acc_next;
        e_reg            <= e_next;
        ts_reg           <= ts_next;
        dv_reg           <= dv_next;
        part_reg         <= part_next;
        tmp_reg          <= tmp_next;
        status_reg       <= status_next;
        kind_reg         <= kind_next;
        symbol_out_reg   <= symbol_out_next;
        sentinel_out_reg <= sentinel_out_next;
        escape_out_reg   <= escape_out_next;
        lower_bound_reg  <= lower_bound_next;
        sym_count_reg    <= sym_count_next;
        total_out_reg    <= total_out_next;
        status_out_reg   <= status_out_next;
    end

    `CFT_ASSERT_IMPL(a_done_after_work, done, $past(busy), "result strobe without work")
    `CFT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
    `CFT_ASSERT_IMPL(a_esc_not_sent, done, !(escape_out && sentinel_out), "escape and sentinel")
    `CFT_ASSERT_NEXT(a_top_grows, 1'b1, top_reg >= $past(top_reg), "top position shrank")

endmodule

// ===== test/cumulative_frequency_table_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for cumulative_frequency_table_core: directed and random increment,
// lookup, decode and spare-mode items, checked against a tree-of-partial-sums predictor kept here.
// Depends on cft_pkg and the core RTL.

module cumulative_frequency_table_core_test;
    import cft_pkg::*;

    localparam logic [MODE_W-1:0]     MODE_SPARE    = 2'd3;
    localparam int unsigned           CYCLE_LIMIT   = 24_000_000;
    localparam int                    SETTLE_CYCLES = 100;
    localparam int                    RANDOM_ITEMS  = 550;
    localparam int                    IDLE_PCT      = 30;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = '1;
    localparam logic [AMT_W-1:0]      AMT_MAX       = '1;

    // how the driver settles a decode target once the running total is known
    typedef enum logic [1:0] {AIM_FIXED, AIM_BELOW, AIM_LAST} aim_e;

    typedef struct packed {
        logic [MODE_W-1:0]     op;
        logic [SYM_W-1:0]      sym;
        logic                  sent;
        logic [AMT_W-1:0]      amt;
        logic [COUNT_BITS-1:0] tgt;
        aim_e                  aim;
        logic                  lax;
    } job_t;

    typedef struct packed {
        logic [SYM_W-1:0]      sym;
        logic                  sent;
        logic                  esc;
        logic [COUNT_BITS-1:0] lo;
        logic [COUNT_BITS-1:0] width;
        logic [COUNT_BITS-1:0] total;
        logic [STATUS_W-1:0]   st;
    } range_t;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic [MODE_W-1:0]     mode        = MODE_LOOKUP;
    logic [SYM_W-1:0]      symbol_in   = '0;
    logic                  sentinel_in = 1'b0;
    logic [AMT_W-1:0]      amount      = '0;
    logic [COUNT_BITS-1:0] target      = '0;
    logic                  busy;
    logic                  done;
    logic [SYM_W-1:0]      symbol_out;
    logic                  sentinel_out;
    logic                  escape_out;
    logic [COUNT_BITS-1:0] lower_bound;
    logic [COUNT_BITS-1:0] sym_count;
    logic [COUNT_BITS-1:0] total_out;
    logic [STATUS_W-1:0]   status;

    cumulative_frequency_table_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .done         (done),
        .mode         (mode),
        .symbol_in    (symbol_in),
        .sentinel_in  (sentinel_in),
        .amount       (amount),
        .target       (target),
        .symbol_out   (symbol_out),
        .sentinel_out (sentinel_out),
        .escape_out   (escape_out),
        .lower_bound  (lower_bound),
        .sym_count    (sym_count),
        .total_out    (total_out),
        .status       (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state: partial sums, highest position in use, sum of symbol counts
    logic [COUNT_BITS-1:0] part_sum [TABLE_DEPTH];
    int unsigned           high_pos;
    logic [COUNT_BITS-1:0] mass;

    job_t        pending[$];
    range_t      ranges_due[$];
    job_t        cur_job;
    range_t      want;
    logic        handed = 1'b0;
    int unsigned faults = 0;
    int unsigned cycles = 0;

    function automatic int unsigned low_one(int unsigned x);
        return x & (~x + 1);
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < TABLE_DEPTH; i++)
            part_sum[i] = '0;
        part_sum[ESC_NODE]  = 1;
        part_sum[SENT_NODE] = 1;
        high_pos = SENT_NODE;
        mass     = 1;
    endfunction

    function automatic logic [COUNT_BITS-1:0] table_total();
        return mass + part_sum[ESC_NODE];
    endfunction

    // cumulative count of every position below pos
    function automatic logic [COUNT_BITS-1:0] sum_before(int unsigned pos);
        int unsigned           p;
        int unsigned           q;
        logic [COUNT_BITS-1:0] acc;
        p   = 1;
        acc = '0;
        while (p < pos)
        begin
            acc = acc + part_sum[p];
            p   = p + p;
        end
        // take back what the covering node holds at and above pos
        q = pos;
        while (q != p && q <= high_pos)
        begin
            acc = acc - part_sum[q];
            q   = q + low_one(q);
        end
        return acc;
    endfunction

    // count held at pos alone
    function automatic logic [COUNT_BITS-1:0] range_width(int unsigned pos);
        logic [COUNT_BITS-1:0] c;
        int unsigned           q;
        int unsigned           z;
        c = part_sum[pos];
        q = pos + 1;
        z = pos + low_one(pos);
        if (z > high_pos + 1)
            z = high_pos + 1;
        while (q < z)
        begin
            c = c - part_sum[q];
            q = q + low_one(q);
        end
        return c;
    endfunction

    function automatic range_t escape_range();
        range_t r;
        r       = '0;
        r.sym   = SYM_W'(high_pos - SENT_NODE);
        r.esc   = 1'b1;
        r.width = part_sum[ESC_NODE];
        return r;
    endfunction

    function automatic range_t symbol_range(int unsigned pos, logic sent, logic [SYM_W-1:0] sym);
        range_t                r;
        logic [COUNT_BITS-1:0] c;
        c = '0;
        if (pos <= high_pos)
            c = range_width(pos);
        if (c == 0)
            return escape_range();
        r       = '0;
        r.sym   = sent ? '0 : sym;
        r.sent  = sent;
        r.lo    = sum_before(pos);
        r.width = c;
        return r;
    endfunction

    function automatic logic [STATUS_W-1:0] bump_count(int unsigned pos, logic sent,
                                                       logic [AMT_W-1:0] amt);
        logic [COUNT_BITS-1:0] esc;
        logic [COUNT_BITS-1:0] c;
        logic [63:0]           grown;
        int unsigned           p;
        esc = part_sum[ESC_NODE];
        if (amt == 0)
            return ST_OK;
        // singletons: first sighting by one raises the escape count, leaving one lowers it
        if (!sent)
        begin
            c = (pos <= high_pos) ? range_width(pos) : '0;
            if (c == 0)
            begin
                if (amt == 1)
                    esc = esc + 1;
            end
            else if (c == 1)
                esc = esc - 1;
        end
        grown = 64'(mass) + 64'(amt) + 64'(esc);
        if (grown > 64'(COUNT_MAX))
            return ST_OVF;
        part_sum[ESC_NODE] = esc;
        if (pos > high_pos)
            high_pos = pos;
        p = pos;
        while (p > 0)
        begin
            part_sum[p] = part_sum[p] + amt;
            p = p & (p - 1);
        end
        mass = mass + amt;
        return ST_OK;
    endfunction

    function automatic range_t find_symbol(logic [COUNT_BITS-1:0] tgt);
        range_t                r;
        int unsigned           p;
        int unsigned           s;
        int unsigned           m;
        logic [COUNT_BITS-1:0] lb;
        logic [COUNT_BITS-1:0] e;
        logic [COUNT_BITS-1:0] part;
        p  = 1;
        lb = '0;
        e  = '0;
        while (p + p <= high_pos && part_sum[p] <= tgt)
        begin
            tgt = tgt - part_sum[p];
            lb  = lb + part_sum[p];
            p   = p + p;
        end
        s = p;
        m = p / 2;
        while (m >= 1)
        begin
            if (s + m <= high_pos)
            begin
                e    = e + part_sum[s + m];
                part = part_sum[s] - e;
                if (part <= tgt)
                begin
                    tgt = tgt - part;
                    lb  = lb + part;
                    s   = s + m;
                    e   = '0;
                end
            end
            m = m / 2;
        end
        if (s == ESC_NODE)
        begin
            r    = escape_range();
            r.lo = lb;
            return r;
        end
        r       = '0;
        r.sym   = (s == SENT_NODE) ? '0 : SYM_W'(s - FIRST_NODE);
        r.sent  = (s == SENT_NODE);
        r.lo    = lb;
        r.width = range_width(s);
        return r;
    endfunction

    // apply one accepted item to the table and give the range it reports
    function automatic range_t advance_table(logic [MODE_W-1:0] op, logic [SYM_W-1:0] sym,
                                             logic sent, logic [AMT_W-1:0] amt,
                                             logic [COUNT_BITS-1:0] tgt);
        range_t              r;
        int unsigned         pos;
        logic [STATUS_W-1:0] st;
        pos = sent ? SENT_NODE : int'(sym) + FIRST_NODE;
        r   = '0;
        st  = ST_OK;
        if (op == MODE_INC || op == MODE_LOOKUP)
        begin
            if (pos >= TABLE_DEPTH)
            begin
                st = ST_RANGE;
                r  = escape_range();
            end
            else
            begin
                if (op == MODE_INC)
                    st = bump_count(pos, sent, amt);
                r = symbol_range(pos, sent, sym);
            end
        end
        else if (op == MODE_DECODE)
        begin
            if (tgt >= table_total())
                st = ST_RANGE;
            else
                r = find_symbol(tgt);
        end
        r.total = table_total();
        r.st    = st;
        return r;
    endfunction

    function automatic void push_job(logic [MODE_W-1:0] op, logic [SYM_W-1:0] sym, logic sent,
                                     logic [AMT_W-1:0] amt, logic [COUNT_BITS-1:0] tgt,
                                     aim_e aim, logic lax);
        job_t j;
        j.op   = op;
        j.sym  = sym;
        j.sent = sent;
        j.amt  = amt;
        j.tgt  = tgt;
        j.aim  = aim;
        j.lax  = lax;
        pending.push_back(j);
    endfunction

    function automatic job_t random_job(logic lax);
        job_t        j;
        int unsigned roll;
        j.lax = lax;
        roll  = $urandom_range(99);
        if (roll < 40)
            j.op = MODE_INC;
        else if (roll < 65)
            j.op = MODE_LOOKUP;
        else if (roll < 95)
            j.op = MODE_DECODE;
        else
            j.op = MODE_SPARE;
        // mostly a small working set so counts build up and singletons come and go
        roll = $urandom_range(99);
        if (roll < 70)
            j.sym = SYM_W'($urandom_range(31));
        else if (roll < 92)
            j.sym = SYM_W'($urandom_range(508));
        else
            j.sym = SYM_W'($urandom_range(511, 509));
        j.sent = ($urandom_range(9) == 0);
        roll   = $urandom_range(99);
        if (roll < 45)
            j.amt = 1;
        else if (roll < 70)
            j.amt = AMT_W'($urandom_range(8, 2));
        else if (roll < 95)
            j.amt = AMT_W'($urandom);
        else
            j.amt = '0;
        j.tgt = $urandom;
        j.aim = ($urandom_range(9) != 0) ? AIM_BELOW : AIM_FIXED;
        return j;
    endfunction

    task automatic wait_quiet();
        while (pending.size() != 0 || start || ranges_due.size() != 0)
            @(posedge clk);
    endtask

    // driver: hold an item until accepted, then advance or idle
    always @(negedge clk)
    begin
        if (rst_n && (!start || handed))
        begin
            if (pending.size() != 0 && !(pending[0].lax && $urandom_range(99) < IDLE_PCT))
            begin
                cur_job = pending.pop_front();
                case (cur_job.aim)
                    AIM_BELOW: cur_job.tgt = $urandom % table_total();
                    AIM_LAST:  cur_job.tgt = table_total() - 1;
                    default:   ;
                endcase
                start       <= 1'b1;
                mode        <= cur_job.op;
                symbol_in   <= cur_job.sym;
                sentinel_in <= cur_job.sent;
                amount      <= cur_job.amt;
                target      <= cur_job.tgt;
            end
            else
                start <= 1'b0;
        end
    end

    // predict at acceptance so the table state always matches the items taken so far
    always @(posedge clk)
    begin
        handed <= rst_n && start && !busy;
        if (rst_n && start && !busy)
            ranges_due.push_back(advance_table(mode, symbol_in, sentinel_in, amount, target));
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (ranges_due.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: sym=%0d sent=%0b esc=%0b lo=%0d cnt=%0d tot=%0d st=%0d",
                             symbol_out, sentinel_out, escape_out, lower_bound, sym_count,
                             total_out, status);
            end
            else
            begin
                want = ranges_due.pop_front();
                if (symbol_out !== want.sym || sentinel_out !== want.sent ||
                    escape_out !== want.esc || lower_bound !== want.lo ||
                    sym_count !== want.width || total_out !== want.total ||
                    status !== want.st)
                begin
                    faults++;
                    if (faults <= 10)
                        $display("mismatch: want sym=%0d sent=%0b esc=%0b lo=%0d cnt=%0d tot=%0d st=%0d / got sym=%0d sent=%0b esc=%0b lo=%0d cnt=%0d tot=%0d st=%0d",
                                 want.sym, want.sent, want.esc, want.lo, want.width,
                                 want.total, want.st, symbol_out, sentinel_out, escape_out,
                                 lower_bound, sym_count, total_out, status);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("** cumulative_frequency_table_core: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [32:0] room;
        int unsigned fills;
        clear_table();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        push_job(MODE_LOOKUP, 9'd0, 1'b0, 16'd1, '0, AIM_FIXED, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, 32'd0, AIM_FIXED, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, 32'd1, AIM_FIXED, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, 32'd2, AIM_FIXED, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, COUNT_MAX, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd0, 1'b0, 16'd1, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd508, 1'b0, AMT_MAX, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd0, 1'b0, 16'd1, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'h1FF, 1'b1, 16'd3, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd5, 1'b0, 16'd0, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd509, 1'b0, 16'd1, '0, AIM_FIXED, 1'b1);
        push_job(MODE_LOOKUP, 9'h1FF, 1'b0, 16'd0, '0, AIM_FIXED, 1'b1);
        push_job(MODE_LOOKUP, 9'd508, 1'b0, 16'd0, '0, AIM_FIXED, 1'b1);
        push_job(MODE_LOOKUP, 9'd300, 1'b0, 16'd0, '0, AIM_FIXED, 1'b1);
        push_job(MODE_LOOKUP, 9'h1FF, 1'b1, 16'd0, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd1, 1'b0, 16'd2, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd1, 1'b0, 16'd1, '0, AIM_FIXED, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, '0, AIM_LAST, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, '0, AIM_BELOW, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, '0, AIM_BELOW, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, '0, AIM_BELOW, 1'b1);
        push_job(MODE_SPARE, 9'h1FF, 1'b1, AMT_MAX, COUNT_MAX, AIM_FIXED, 1'b1);
        push_job(MODE_LOOKUP, 9'd0, 1'b0, 16'd0, '0, AIM_FIXED, 1'b1);

        // one long stretch in the middle runs back to back
        for (int i = 0; i < RANDOM_ITEMS; i++)
            pending.push_back(random_job(!(i >= 200 && i < 350)));

        // fill the total up to the edge of the count width through the sentinel
        wait_quiet();
        room  = 33'(COUNT_MAX) - 33'(table_total());
        fills = room / AMT_MAX;
        for (int i = 0; i < fills; i++)
            push_job(MODE_INC, 9'd0, 1'b1, AMT_MAX, '0, AIM_FIXED, 1'b0);
        wait_quiet();
        room = 33'(COUNT_MAX) - 33'(table_total());
        push_job(MODE_INC, 9'd7, 1'b1, room[AMT_W-1:0], '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd0, 1'b1, 16'd1, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd0, 1'b0, AMT_MAX, '0, AIM_FIXED, 1'b1);
        push_job(MODE_INC, 9'd507, 1'b0, 16'd1, '0, AIM_FIXED, 1'b1);
        push_job(MODE_LOOKUP, 9'd0, 1'b1, 16'd0, '0, AIM_FIXED, 1'b1);
        push_job(MODE_LOOKUP, 9'd508, 1'b0, 16'd0, '0, AIM_FIXED, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, '0, AIM_LAST, 1'b1);
        push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, COUNT_MAX, AIM_FIXED, 1'b1);
        for (int i = 0; i < 8; i++)
            push_job(MODE_DECODE, 9'd0, 1'b0, 16'd0, '0, AIM_BELOW, 1'b1);
        push_job(MODE_SPARE, 9'd0, 1'b0, 16'd0, '0, AIM_FIXED, 1'b1);

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("** cumulative_frequency_table_core: PASSED **");
        else
            $display("** cumulative_frequency_table_core: FAILED **");
        $finish;
    end

endmodule
